// ----- rtl/odo_pkg.sv -----
// Shared types, constants and helper functions of the wheel odometry block.
package odo_pkg;

  localparam int unsigned IdxW           = 5;
  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned FracBitsDef    = 16;

  localparam logic [31:0] LengthPerCountRst = 32'd29127704;
  localparam logic [31:0] AnglePerLengthRst = 32'd6485370;
  localparam logic [31:0] CordicGain        = 32'd652032874;

  localparam logic RegLengthPerCount = 1'b0;
  localparam logic RegAnglePerLength = 1'b1;

  localparam logic signed [63:0] PosMax = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] PosMin = 64'shFFFF_8000_0000_0000;

  typedef struct packed {
    logic            load;
    logic            clear;
    logic            wheel;
    logic            diff;
    logic            angle;
    logic            mid;
    logic            prep;
    logic            rot;
    logic            fix;
    logic            scale;
    logic            step;
    logic            update;
    logic [IdxW-1:0] idx;
  } cmd_t;

  function automatic logic [31:0] atan_angle(input logic [IdxW-1:0] i);
    logic [31:0] a;
    case (i)
      5'd0:    a = 32'd536870912;
      5'd1:    a = 32'd316933406;
      5'd2:    a = 32'd167458907;
      5'd3:    a = 32'd85004757;
      5'd4:    a = 32'd42667331;
      5'd5:    a = 32'd21354465;
      5'd6:    a = 32'd10679838;
      5'd7:    a = 32'd5340247;
      5'd8:    a = 32'd2670163;
      5'd9:    a = 32'd1335087;
      5'd10:   a = 32'd667544;
      5'd11:   a = 32'd333772;
      5'd12:   a = 32'd166886;
      5'd13:   a = 32'd83443;
      5'd14:   a = 32'd41722;
      5'd15:   a = 32'd20861;
      5'd16:   a = 32'd10430;
      5'd17:   a = 32'd5215;
      5'd18:   a = 32'd2608;
      5'd19:   a = 32'd1304;
      5'd20:   a = 32'd652;
      5'd21:   a = 32'd326;
      5'd22:   a = 32'd163;
      5'd23:   a = 32'd81;
      5'd24:   a = 32'd41;
      5'd25:   a = 32'd20;
      5'd26:   a = 32'd10;
      5'd27:   a = 32'd5;
      5'd28:   a = 32'd3;
      5'd29:   a = 32'd1;
      5'd30:   a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

  function automatic logic [47:0] sat48(input logic signed [63:0] v);
    logic [47:0] r;
    if (v > PosMax) begin
      r = PosMax[47:0];
    end else if (v < PosMin) begin
      r = PosMin[47:0];
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/odo_ctrl.sv -----
// Sequencer that steps one odometry item through the shared datapath.
module odo_ctrl #(
  parameter int unsigned CORDIC_STEPS = odo_pkg::CordicStepsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_clear_i,
  input  logic          out_free_i,
  output logic          in_ready_o,
  output logic          out_load_o,
  output odo_pkg::cmd_t cmd_o
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_WHEEL  = 12'b0000_0000_0010,
    S_DIFF   = 12'b0000_0000_0100,
    S_ANGLE  = 12'b0000_0000_1000,
    S_MID    = 12'b0000_0001_0000,
    S_PREP   = 12'b0000_0010_0000,
    S_ROT    = 12'b0000_0100_0000,
    S_FIX    = 12'b0000_1000_0000,
    S_SCALE  = 12'b0001_0000_0000,
    S_STEP   = 12'b0010_0000_0000,
    S_UPDATE = 12'b0100_0000_0000,
    S_OUT    = 12'b1000_0000_0000
  } state_e;

  localparam logic [odo_pkg::IdxW-1:0] LastRot   = odo_pkg::IdxW'(CORDIC_STEPS - 1);
  localparam logic [odo_pkg::IdxW-1:0] LastScale = odo_pkg::IdxW'(3);

  state_e                     state_q, state_d;
  logic [odo_pkg::IdxW-1:0]   cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    cmd_o.idx  = cnt_q;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load  = 1'b1;
          cmd_o.clear = in_clear_i;
          cnt_d       = '0;
          state_d     = in_clear_i ? S_OUT : S_WHEEL;
        end
      end
      S_WHEEL: begin
        cmd_o.wheel = 1'b1;
        if (cnt_q[0]) begin
          cnt_d   = '0;
          state_d = S_DIFF;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = S_ANGLE;
      end
      S_ANGLE: begin
        cmd_o.angle = 1'b1;
        if (cnt_q[0]) begin
          cnt_d   = '0;
          state_d = S_MID;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_MID: begin
        cmd_o.mid = 1'b1;
        state_d   = S_PREP;
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        cnt_d      = '0;
        state_d    = S_ROT;
      end
      S_ROT: begin
        cmd_o.rot = 1'b1;
        if (cnt_q == LastRot) begin
          cnt_d   = '0;
          state_d = S_FIX;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_FIX: begin
        cmd_o.fix = 1'b1;
        cnt_d     = '0;
        state_d   = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        if (cnt_q == LastScale) begin
          cnt_d   = '0;
          state_d = S_STEP;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_STEP: begin
        cmd_o.step = 1'b1;
        state_d    = S_UPDATE;
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

`ifndef SYNTH
  a_clear_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_clear_i |=> state_q == S_OUT)
    else $error("clear item did not go straight to output");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while busy");

  a_rot_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ROT && cnt_q != LastRot |=>
      state_q == S_ROT && cnt_q == odo_pkg::IdxW'($past(cnt_q) + 1'b1))
    else $error("rotation count skipped");

  a_rot_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ROT && cnt_q == LastRot |=> state_q == S_FIX)
    else $error("rotation loop overran");
`endif

endmodule

// ----- rtl/odo_dpath.sv -----
// Datapath: pose state, shared multiplier, and CORDIC rotation registers.
module odo_dpath #(
  parameter int unsigned FRACTION_BITS = odo_pkg::FracBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  odo_pkg::cmd_t cmd_i,
  input  logic [31:0]   left_count_i,
  input  logic [31:0]   right_count_i,
  input  logic [31:0]   length_per_count_i,
  input  logic [31:0]   angle_per_length_i,
  output logic [47:0]   x_position_o,
  output logic [47:0]   y_position_o,
  output logic [31:0]   heading_o
);

  localparam int unsigned MmW   = 32 + FRACTION_BITS;
  localparam int unsigned DiffW = MmW + 1;
  localparam int unsigned AngW  = FRACTION_BITS + 33;

  logic [31:0]              prev_l_q, prev_r_q;
  logic [47:0]              pose_x_q, pose_y_q;
  logic [31:0]              heading_q;

  logic [31:0]              dl_q, dr_q;
  logic signed [MmW-1:0]    lmm_q, rmm_q;
  logic [DiffW-1:0]         diff_q;
  logic [47:0]              centre_q;
  logic [AngW-1:0]          p1_q;
  logic [FRACTION_BITS:0]   p2_q;
  logic [31:0]              dth_q, half_q;
  logic                     flip_q;
  logic signed [31:0]       x_q, y_q, c_q, s_q;
  logic signed [32:0]       z_q;
  logic signed [63:0]       xhi_q, yhi_q;
  logic signed [31:0]       xlo_q, ylo_q;
  logic signed [49:0]       step_x_q, step_y_q;

  logic signed [32:0]       mul_a, mul_b;
  logic signed [65:0]       mul_p;
  logic signed [31:0]       trig_sel;

  logic [DiffW-1:0]         sum_c, diff_w;
  logic [MmW-1:0]           centre_w;
  logic [AngW-1:0]          ang_sum;
  logic [31:0]              mid, ang;
  logic                     flip;
  logic signed [31:0]       sx, sy;
  logic signed [32:0]       atan_w;
  logic [63:0]              step_x_sum, step_y_sum;
  logic [50:0]              px_sum, py_sum;

  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    trig_sel = cmd_i.idx[1] ? s_q : c_q;
    if (cmd_i.wheel) begin
      mul_a = cmd_i.idx[0] ? {dr_q[31], dr_q} : {dl_q[31], dl_q};
      mul_b = {1'b0, length_per_count_i};
    end else if (cmd_i.angle) begin
      mul_a = cmd_i.idx[0] ? 33'(diff_q[DiffW-1:32]) : {1'b0, diff_q[31:0]};
      mul_b = {1'b0, angle_per_length_i};
    end else if (cmd_i.scale) begin
      mul_a = cmd_i.idx[0] ? {17'd0, centre_q[15:0]} : {centre_q[47], centre_q[47:16]};
      mul_b = {trig_sel[31], trig_sel};
    end
  end

  assign mul_p = mul_a * mul_b;

  assign sum_c    = {lmm_q[MmW-1], lmm_q} + {rmm_q[MmW-1], rmm_q};
  assign diff_w   = {rmm_q[MmW-1], rmm_q} - {lmm_q[MmW-1], lmm_q};
  assign centre_w = sum_c[MmW:1];

  assign ang_sum = p1_q + {p2_q, 32'd0};

  assign mid  = heading_q + half_q;
  assign flip = mid[31] ^ mid[30];
  assign ang  = {mid[31] ^ flip, mid[30:0]};

  assign sx     = x_q >>> cmd_i.idx;
  assign sy     = y_q >>> cmd_i.idx;
  assign atan_w = {1'b0, odo_pkg::atan_angle(cmd_i.idx)};

  assign step_x_sum = xhi_q + {{32{xlo_q[31]}}, xlo_q};
  assign step_y_sum = yhi_q + {{32{ylo_q[31]}}, ylo_q};

  assign px_sum = {{3{pose_x_q[47]}}, pose_x_q} + {step_x_q[49], step_x_q};
  assign py_sum = {{3{pose_y_q[47]}}, pose_y_q} + {step_y_q[49], step_y_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_l_q  <= '0;
      prev_r_q  <= '0;
      pose_x_q  <= '0;
      pose_y_q  <= '0;
      heading_q <= '0;
    end else if (cmd_i.load && cmd_i.clear) begin
      prev_l_q  <= '0;
      prev_r_q  <= '0;
      pose_x_q  <= '0;
      pose_y_q  <= '0;
      heading_q <= '0;
    end else if (cmd_i.load) begin
      prev_l_q <= left_count_i;
      prev_r_q <= right_count_i;
    end else if (cmd_i.update) begin
      pose_x_q  <= odo_pkg::sat48({{13{px_sum[50]}}, px_sum});
      pose_y_q  <= odo_pkg::sat48({{13{py_sum[50]}}, py_sum});
      heading_q <= heading_q + dth_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dl_q <= left_count_i - prev_l_q;
      dr_q <= right_count_i - prev_r_q;
    end
    if (cmd_i.wheel) begin
      if (cmd_i.idx[0]) begin
        rmm_q <= mul_p[63:32-FRACTION_BITS];
      end else begin
        lmm_q <= mul_p[63:32-FRACTION_BITS];
      end
    end
    if (cmd_i.diff) begin
      diff_q   <= diff_w;
      centre_q <= odo_pkg::sat48({{(64-MmW){centre_w[MmW-1]}}, centre_w});
    end
    if (cmd_i.angle) begin
      if (cmd_i.idx[0]) begin
        p2_q <= mul_p[FRACTION_BITS:0];
      end else begin
        p1_q <= mul_p[AngW-1:0];
      end
    end
    if (cmd_i.mid) begin
      dth_q  <= ang_sum[FRACTION_BITS+31:FRACTION_BITS];
      half_q <= ang_sum[FRACTION_BITS+32:FRACTION_BITS+1];
    end
    if (cmd_i.prep) begin
      flip_q <= flip;
      z_q    <= {ang[31], ang};
      x_q    <= odo_pkg::CordicGain;
      y_q    <= '0;
    end
    if (cmd_i.rot) begin
      if (!z_q[32]) begin
        x_q <= x_q - sy;
        y_q <= y_q + sx;
        z_q <= z_q - atan_w;
      end else begin
        x_q <= x_q + sy;
        y_q <= y_q - sx;
        z_q <= z_q + atan_w;
      end
    end
    if (cmd_i.fix) begin
      c_q <= flip_q ? -x_q : x_q;
      s_q <= flip_q ? -y_q : y_q;
    end
    if (cmd_i.scale) begin
      case (cmd_i.idx[1:0])
        2'd0:    xhi_q <= mul_p[63:0];
        2'd1:    xlo_q <= mul_p[47:16];
        2'd2:    yhi_q <= mul_p[63:0];
        default: ylo_q <= mul_p[47:16];
      endcase
    end
    if (cmd_i.step) begin
      step_x_q <= step_x_sum[63:14];
      step_y_q <= step_y_sum[63:14];
    end
  end

  assign x_position_o = pose_x_q;
  assign y_position_o = pose_y_q;
  assign heading_o    = heading_q;

endmodule

// ----- rtl/differential_drive_odometry.sv -----
// Top level of the differential-drive wheel odometry block.
// Each input item carries absolute left and right encoder counts (or a clear
// request in tuser) and yields one output item with the pose after it: x and y
// in signed fixed point with FRACTION_BITS fraction bits, and the heading as a
// 32-bit binary angle. An update item passes through the single 33x33
// multiplier, which forms eight products in turn, and through the CORDIC loop,
// which performs one rotation per cycle; a clear item goes straight to the
// output state. A new item is accepted once the previous result has moved
// into the output register.
module differential_drive_odometry #(
  parameter int unsigned CORDIC_STEPS  = odo_pkg::CordicStepsDef,
  parameter int unsigned FRACTION_BITS = odo_pkg::FracBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_addr_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // left_count[31:0], right_count[63:32]
  input  logic [0:0]   s_axis_tuser,   // kind[0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata    // x_position[47:0], y_position[95:48], heading[127:96]
);

  logic [31:0]   length_per_count_q, angle_per_length_q;
  logic          out_valid_q;
  logic [127:0]  out_data_q;
  logic          out_free, out_load;
  odo_pkg::cmd_t cmd;
  logic [47:0]   x_position, y_position;
  logic [31:0]   heading;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_per_count_q <= odo_pkg::LengthPerCountRst;
      angle_per_length_q <= odo_pkg::AnglePerLengthRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        odo_pkg::RegLengthPerCount: length_per_count_q <= cfg_wdata_i;
        odo_pkg::RegAnglePerLength: angle_per_length_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_q || m_axis_tready;

  odo_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_clear_i (s_axis_tuser[0]),
    .out_free_i (out_free),
    .in_ready_o (s_axis_tready),
    .out_load_o (out_load),
    .cmd_o      (cmd)
  );

  odo_dpath #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .left_count_i       (s_axis_tdata[31:0]),
    .right_count_i      (s_axis_tdata[63:32]),
    .length_per_count_i (length_per_count_q),
    .angle_per_length_i (angle_per_length_q),
    .x_position_o       (x_position),
    .y_position_o       (y_position),
    .heading_o          (heading)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {heading, y_position, x_position};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ----- tb/differential_drive_odometry_test.sv -----
// Self-checking testbench for the differential-drive wheel odometry block.
module differential_drive_odometry_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic KindUpdate = 1'b0;
  localparam logic KindClear  = 1'b1;

  localparam int unsigned Steps    = 16;
  localparam int unsigned FracBits = 16;

  localparam logic [31:0] DefaultLengthPerCount = 32'd29127704;
  localparam logic [31:0] DefaultAnglePerLength = 32'd6485370;

  localparam longint GainQ30 = 64'sd652032874;
  localparam longint PoseMax = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint PoseMin = -PoseMax - 1;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned ShownMismatches = 10;

  typedef struct packed {
    logic [31:0] heading;
    logic [47:0] y;
    logic [47:0] x;
  } pose_t;

  logic         clk = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we = 1'b0;
  logic         cfg_addr = 1'b0;
  logic [31:0]  cfg_wdata = '0;
  logic         s_valid = 1'b0;
  logic         s_ready;
  logic [63:0]  s_data = '0;   // left_count[31:0], right_count[63:32]
  logic [0:0]   s_user = '0;   // kind[0]
  logic         m_valid;
  logic         m_ready = 1'b0;
  logic [127:0] m_data;        // x_position[47:0], y_position[95:48], heading[127:96]

  logic [31:0] length_per_count = DefaultLengthPerCount;
  logic [31:0] angle_per_length = DefaultAnglePerLength;
  logic [31:0] last_left = '0;
  logic [31:0] last_right = '0;
  longint      pose_x = 0;
  longint      pose_y = 0;
  logic [31:0] pose_heading = '0;

  logic [31:0] walk_left = '0;
  logic [31:0] walk_right = '0;

  pose_t       expected_poses[$];
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit          quiet = 1'b0;

  differential_drive_odometry DUT (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint arc_tangent(int unsigned i);
    longint a;
    case (i)
      0:       a = 536870912;
      1:       a = 316933406;
      2:       a = 167458907;
      3:       a = 85004757;
      4:       a = 42667331;
      5:       a = 21354465;
      6:       a = 10679838;
      7:       a = 5340247;
      8:       a = 2670163;
      9:       a = 1335087;
      10:      a = 667544;
      11:      a = 333772;
      12:      a = 166886;
      13:      a = 83443;
      14:      a = 41722;
      15:      a = 20861;
      default: a = 0;
    endcase
    return a;
  endfunction

  function automatic longint clamp_pose(longint v);
    longint r;
    if (v > PoseMax) begin
      r = PoseMax;
    end else if (v < PoseMin) begin
      r = PoseMin;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic longint wheel_travel(logic [31:0] count, logic [31:0] last);
    logic [31:0] d;
    longint      delta;
    longint      factor;
    d = count - last;
    delta = longint'($signed(d));
    factor = longint'({32'h0, length_per_count});
    return (delta * factor) >>> (32 - FracBits);
  endfunction

  function automatic void rotate_unit(input logic [31:0] angle, output longint cos_q30,
                                      output longint sin_q30);
    logic [31:0] a;
    bit          flip;
    longint      x;
    longint      y;
    longint      z;
    longint      nx;
    a = angle;
    flip = (a[31:30] == 2'b01) || (a[31:30] == 2'b10);
    if (flip) begin
      a = a - 32'h8000_0000;
    end
    z = longint'($signed(a));
    x = GainQ30;
    y = 0;
    for (int unsigned i = 0; i < Steps; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - arc_tangent(i);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + arc_tangent(i);
      end
      x = nx;
    end
    cos_q30 = flip ? -x : x;
    sin_q30 = flip ? -y : y;
  endfunction

  function automatic longint scale_by_unit(longint d, longint c);
    longint hi;
    longint lo;
    hi = d >>> 16;
    lo = d - hi * 65536;
    return (hi * c + ((lo * c) >>> 16)) >>> 14;
  endfunction

  function automatic pose_t advance_pose(logic kind, logic [31:0] left, logic [31:0] right);
    longint      lmm;
    longint      rmm;
    longint      centre;
    longint      c;
    longint      s;
    logic [63:0] span;
    logic [63:0] turn;
    logic [31:0] full_turn;
    logic [31:0] half_turn;
    pose_t       p;
    if (kind == KindClear) begin
      last_left = '0;
      last_right = '0;
      pose_x = 0;
      pose_y = 0;
      pose_heading = '0;
    end else begin
      lmm = wheel_travel(left, last_left);
      rmm = wheel_travel(right, last_right);
      centre = clamp_pose((lmm + rmm) >>> 1);
      span = rmm - lmm;
      turn = span * {32'h0, angle_per_length};
      full_turn = turn[FracBits +: 32];
      half_turn = turn[FracBits + 1 +: 32];
      last_left = left;
      last_right = right;
      rotate_unit(pose_heading + half_turn, c, s);
      pose_x = clamp_pose(pose_x + scale_by_unit(centre, c));
      pose_y = clamp_pose(pose_y + scale_by_unit(centre, s));
      pose_heading = pose_heading + full_turn;
    end
    p.x = pose_x[47:0];
    p.y = pose_y[47:0];
    p.heading = pose_heading;
    return p;
  endfunction

  task automatic pause_sender(int unsigned cycles);
    @(negedge clk);
    s_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic send_item(logic kind, logic [31:0] left, logic [31:0] right);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      pause_sender($urandom_range(1, 16));
    end
    @(negedge clk);
    s_valid <= 1'b1;
    s_user <= kind;
    s_data <= {right, left};
    forever begin
      @(posedge clk);
      if (s_ready) break;
    end
    expected_poses.push_back(advance_pose(kind, left, right));
  endtask

  task automatic wait_drained;
    @(negedge clk);
    s_valid <= 1'b0;
    while (expected_poses.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_register(logic idx, logic [31:0] value);
    wait_drained();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == odo_pkg::RegLengthPerCount) begin
      length_per_count = value;
    end else begin
      angle_per_length = value;
    end
  endtask

  task automatic set_scales(logic [31:0] per_count, logic [31:0] per_length);
    write_register(odo_pkg::RegLengthPerCount, per_count);
    write_register(odo_pkg::RegAnglePerLength, per_length);
  endtask

  task automatic clear_pose;
    send_item(KindClear, $urandom, $urandom);
    walk_left = '0;
    walk_right = '0;
  endtask

  task automatic drive_to(logic [31:0] left, logic [31:0] right);
    send_item(KindUpdate, left, right);
    walk_left = left;
    walk_right = right;
  endtask

  // Mostly plausible wheel motion; a few clears, big jumps and raw noise.
  task automatic step_robot;
    int          dl;
    int          dr;
    logic        kind;
    logic [31:0] left;
    logic [31:0] right;
    case ($urandom_range(0, 19))
      0: begin
        clear_pose();
      end
      1, 2: begin
        kind = 1'($urandom_range(0, 1));
        left = $urandom;
        right = $urandom;
        send_item(kind, left, right);
        walk_left = (kind == KindClear) ? '0 : left;
        walk_right = (kind == KindClear) ? '0 : right;
      end
      3: begin
        dl = $urandom_range(0, 2097152) - 1048576;
        dr = $urandom_range(0, 2097152) - 1048576;
        drive_to(walk_left + dl, walk_right + dr);
      end
      default: begin
        dl = $urandom_range(0, 4000) - 2000;
        dr = dl + $urandom_range(0, 600) - 300;
        drive_to(walk_left + dl, walk_right + dr);
      end
    endcase
  endtask

  task automatic test_directed_cases;
    drive_to(32'd0, 32'd0);
    drive_to(32'd1000, 32'd1000);
    drive_to(32'd2000, 32'd2000);
    drive_to(32'd2000, 32'd3000);
    drive_to(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    drive_to(32'h8000_0000, 32'h8000_0000);
    drive_to(32'h8000_0000, 32'h7FFF_FFFF);
    drive_to(32'hFFFF_FFFF, 32'd0);
    drive_to(32'd0, 32'hFFFF_FFFF);
    clear_pose();
    // turn past pi, then a change of several turns
    drive_to(32'd0, 32'd60000);
    drive_to(-32'd1000000, 32'd1000000);
    set_scales(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    clear_pose();
    drive_to(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    drive_to(32'hFFFF_FFFE, 32'hFFFF_FFFE);
    drive_to(32'h7FFF_FFFD, 32'h7FFF_FFFD);
    clear_pose();
    drive_to(32'h8000_0000, 32'h8000_0000);
    drive_to(32'd0, 32'd0);
    drive_to(32'h8000_0000, 32'h8000_0000);
    drive_to(32'h8000_0000, 32'h0000_0000);
    set_scales(32'd0, 32'd0);
    drive_to(32'h1234_5678, 32'h8765_4321);
    set_scales(DefaultLengthPerCount, DefaultAnglePerLength);
  endtask

  task automatic test_register_settings;
    logic [31:0] per_count[6];
    logic [31:0] per_length[6];
    per_count = '{32'd0, 32'hFFFF_FFFF, DefaultLengthPerCount, 32'd1, $urandom,
                  DefaultLengthPerCount};
    per_length = '{32'd0, 32'hFFFF_FFFF, DefaultAnglePerLength, 32'd1, $urandom, $urandom};
    for (int i = 0; i < 6; i++) begin
      set_scales(per_count[i], per_length[i]);
      clear_pose();
      repeat (40) step_robot();
    end
  endtask

  task automatic test_random_motion;
    for (int phase = 0; phase < 16; phase++) begin
      if (phase % 4 == 3) begin
        set_scales($urandom, $urandom);
      end else begin
        set_scales($urandom_range(1 << 20, 1 << 26), $urandom_range(1 << 20, 1 << 24));
      end
      for (int n = 0; n < 100; n++) begin
        if ((phase == 0 && n == 50) || $urandom_range(0, 199) == 0) begin
          wait_drained();
        end
        step_robot();
      end
    end
  endtask

  task automatic test_quiet_finish;
    set_scales(DefaultLengthPerCount, DefaultAnglePerLength);
    quiet = 1'b1;
    repeat (200) step_robot();
  endtask

  always @(negedge clk) begin
    if (stall_left != 0) begin
      m_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      m_ready <= 1'b0;
      stall_left = $urandom_range(0, 15);
    end else begin
      m_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    pose_t got;
    pose_t want;
    if (rst_ni && m_valid && m_ready) begin
      got = m_data;
      if (expected_poses.size() == 0) begin
        errors++;
        if (errors <= ShownMismatches) begin
          $display("pose with none pending: x=%h y=%h heading=%h", got.x, got.y, got.heading);
        end
      end else begin
        want = expected_poses.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.heading !== want.heading) begin
          errors++;
          if (errors <= ShownMismatches) begin
            $display("pose mismatch: expected x=%h y=%h heading=%h, got x=%h y=%h heading=%h",
                     want.x, want.y, want.heading, got.x, got.y, got.heading);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("differential_drive_odometry_test: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_register_settings();
    test_random_motion();
    test_quiet_finish();
    wait_drained();
    if (errors == 0) begin
      $display("differential_drive_odometry_test: done, clean");
    end else begin
      $display("differential_drive_odometry_test: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/odo_pkg.sv
rtl/odo_ctrl.sv
rtl/odo_dpath.sv
rtl/differential_drive_odometry.sv
tb/differential_drive_odometry_test.sv
